// ===== rtl/tpfcc_pkg.sv =====
`default_nettype none

package tpfcc_pkg;

    // Packet header constants.
    localparam logic [7:0]  SYNC_BYTE     = 8'h47;
    localparam logic [12:0] NULL_PID      = 13'h1fff;
    localparam int          PID_W         = 13;

    // Payload buffer sizing.
    localparam int          BUFFER_BYTES  = 4096;
    localparam int          PAYLOAD_BYTES = 184;
    localparam int          FILL_W        = 13;
    localparam int          OFFSET_W      = 12;
    localparam logic [FILL_W-1:0] FILL_LIMIT   = FILL_W'(BUFFER_BYTES - PAYLOAD_BYTES);
    localparam logic [FILL_W-1:0] PAYLOAD_STEP = FILL_W'(PAYLOAD_BYTES);

    // The clock reference in milliseconds is base / 90. The base is halved first,
    // then divided by 45 through a reciprocal multiply and a one-step correction.
    localparam int          PCR_MS_W        = 27;
    localparam int          PCR_DIV         = 90;
    localparam int          PCR_HALF_DIV    = PCR_DIV / 2;
    localparam int          PCR_RECIP_SHIFT = 37;
    localparam logic [31:0] PCR_RECIP       =
        32'((64'd1 << PCR_RECIP_SHIFT) / 64'(PCR_HALF_DIV));
    localparam int          PCR_REM_W       = 7;

    // Queue between the classifier and the packet handler.
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

    // Stream widths.
    localparam int          S_TDATA_W = 88;
    localparam int          M_TDATA_W = 56;
    localparam int          M_TUSER_W = 3;

    // Packet class found by the classifier.
    typedef enum logic [2:0] {
        KIND_BAD_SYNC,
        KIND_TERR,
        KIND_NULL,
        KIND_OTHER,
        KIND_TARGET
    } t_kind;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_BAD_SYNC = 3'd0,
        STATUS_TERR     = 3'd1,
        STATUS_NULL     = 3'd2,
        STATUS_OTHER    = 3'd3,
        STATUS_WAIT     = 3'd4,
        STATUS_APPEND   = 3'd5,
        STATUS_OVERFLOW = 3'd6
    } t_status;

    // One classified packet as it travels through the queue.
    typedef struct packed {
        t_kind                kind;
        logic                 pusi;
        logic                 disc;
        logic [3:0]           cc;
        logic                 pcr_load;
        logic [PCR_MS_W-1:0]  pcr_q0;
        logic [PCR_REM_W-1:0] pcr_x_lo;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/ts_pid_filter_continuity_check.sv =====
// A header beat is written into the queue and then, once the output register is
// free, into the output register that drives o_m_tvalid.
// Throughput: one header beat per cycle; the four-entry queue between the
// classifier and the packet handler absorbs output stalls before tready drops.
// Reset (i_rst_n low at a clock edge) empties the queue and the output register and
// clears the target PID, the continuity state, the fill count and the latched clock.
`default_nettype none

module ts_pid_filter_continuity_check
    import tpfcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Target PID register write.
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [PID_W-1:0]     i_cfg_wr_data,
    // Header beats.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // From bit 0: header_word[31:0], adapt_flags[39:32], pcr_bytes[87:40].
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // Result beats.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // From bit 0: cc_gap[0], deliver_prev[1], deliver_len[14:2],
    // write_offset[26:15], pcr_ms[53:27], zero fill[55:54].
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // From bit 0: status[2:0].
    output logic [M_TUSER_W-1:0]      o_m_tuser
);

    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_valid;
    t_item push_item;
    t_item head_item;

    tpfcc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tdata     (i_s_tdata),
        .i_queue_full  (queue_full),
        .o_s_tready    (o_s_tready),
        .o_push        (push),
        .o_item        (push_item)
    );

    tpfcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (head_item)
    );

    tpfcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .i_item     (head_item),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/tpfcc_front.sv =====
`default_nettype none

module tpfcc_front
    import tpfcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [PID_W-1:0]     i_cfg_wr_data,
    input  wire logic                 i_s_tvalid,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_queue_full,
    output logic                      o_s_tready,
    output logic                      o_push,
    output t_item                     o_item
);

    logic [PID_W-1:0] r_target_pid;
    logic [PID_W-1:0] n_target_pid;

    logic [31:0] header_word;
    logic [7:0]  adapt_flags;
    logic [47:0] pcr_bytes;
    logic [12:0] pid;
    logic        adapt;
    logic [31:0] pcr_half;
    logic [63:0] pcr_prod;

    // Target PID register; write only while the block is idle (not enforced here).
    always_comb begin
        n_target_pid = r_target_pid;
        if (i_cfg_wr_en) begin
            n_target_pid = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pid <= '0;
        end else begin
            r_target_pid <= n_target_pid;
        end
    end

    // Field extraction from the input beat.
    assign header_word = i_s_tdata[31:0];
    assign adapt_flags = i_s_tdata[39:32];
    assign pcr_bytes   = i_s_tdata[87:40];
    assign pid         = header_word[20:8];
    assign adapt       = header_word[5];

    // Reciprocal multiply: an estimate of (base / 2) / 45 that is low by at most one.
    assign pcr_half = pcr_bytes[47:16];
    assign pcr_prod = {32'd0, pcr_half} * {32'd0, PCR_RECIP};

    // Classification of the packet.
    always_comb begin
        o_item          = '0;
        o_item.pusi     = header_word[22];
        o_item.disc     = adapt & adapt_flags[7];
        o_item.cc       = header_word[3:0];
        o_item.pcr_q0   = pcr_prod[PCR_RECIP_SHIFT +: PCR_MS_W];
        o_item.pcr_x_lo = pcr_half[PCR_REM_W-1:0];
        o_item.pcr_load = 1'b0;
        if (header_word[31:24] != SYNC_BYTE) begin
            o_item.kind = KIND_BAD_SYNC;
        end else if (header_word[23]) begin
            o_item.kind = KIND_TERR;
        end else begin
            o_item.pcr_load = adapt & adapt_flags[4];
            if (pid == NULL_PID) begin
                o_item.kind = KIND_NULL;
            end else if (pid != r_target_pid) begin
                o_item.kind = KIND_OTHER;
            end else begin
                o_item.kind = KIND_TARGET;
            end
        end
    end

    // A beat goes into the queue whenever it has room.
    assign o_s_tready = ~i_queue_full;
    assign o_push     = i_s_tvalid & ~i_queue_full;

endmodule

`default_nettype wire

// ===== rtl/tpfcc_queue.sv =====
`default_nettype none

module tpfcc_queue
    import tpfcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    // Pointer and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpfcc_back.sv =====
`default_nettype none

module tpfcc_back
    import tpfcc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_item                i_item,
    output logic                      o_pop,
    input  wire logic                 i_m_tready,
    output logic                      o_m_tvalid,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic [M_TUSER_W-1:0]      o_m_tuser
);

    // Stream state.
    logic [3:0]          r_cc_exp;
    logic                r_cc_known;
    logic [FILL_W-1:0]   r_fill;
    logic [PCR_MS_W-1:0] r_pcr_ms;
    logic [3:0]          n_cc_exp;
    logic                n_cc_known;
    logic [FILL_W-1:0]   n_fill;
    logic [PCR_MS_W-1:0] n_pcr_ms;

    // Output register.
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;
    logic                n_out_valid;

    // Result fields of the packet being handled.
    t_status             status;
    logic                gap;
    logic                deliver;
    logic [FILL_W-1:0]   dlen;
    logic [OFFSET_W-1:0] offset;
    logic [3:0]          cc_next;
    logic [FILL_W-1:0]   fill_mid;

    // Clock reference correction.
    logic [12:0]          q0_x45;
    logic [PCR_REM_W-1:0] pcr_rem;
    logic [PCR_MS_W-1:0]  pcr_q;

    assign o_pop = i_valid & (~r_out_valid | i_m_tready);

    // The estimate is low by at most one: a remainder of 45 or more bumps it.
    assign q0_x45  = {6'd0, i_item.pcr_q0[PCR_REM_W-1:0]} * 13'(PCR_HALF_DIV);
    assign pcr_rem = i_item.pcr_x_lo - q0_x45[PCR_REM_W-1:0];
    assign pcr_q   = i_item.pcr_q0
                   + {{(PCR_MS_W-1){1'b0}}, (pcr_rem >= PCR_REM_W'(PCR_HALF_DIV))};

    // Continuity check and fill accounting for one packet.
    always_comb begin
        n_cc_exp   = r_cc_exp;
        n_cc_known = r_cc_known;
        n_fill     = r_fill;
        n_pcr_ms   = r_pcr_ms;
        gap        = 1'b0;
        deliver    = 1'b0;
        dlen       = '0;
        offset     = '0;
        cc_next    = r_cc_exp + 4'd1;
        fill_mid   = r_fill;
        status     = STATUS_BAD_SYNC;

        if (i_item.pcr_load) begin
            n_pcr_ms = pcr_q;
        end

        case (i_item.kind)
            KIND_BAD_SYNC: status = STATUS_BAD_SYNC;
            KIND_TERR:     status = STATUS_TERR;
            KIND_NULL:     status = STATUS_NULL;
            KIND_OTHER:    status = STATUS_OTHER;
            KIND_TARGET: begin
                if (!r_cc_known) begin
                    n_cc_exp   = i_item.cc;
                    n_cc_known = 1'b1;
                end else if (!i_item.disc) begin
                    n_cc_exp = cc_next;
                    if (i_item.cc != cc_next) begin
                        gap        = 1'b1;
                        fill_mid   = '0;
                        n_cc_known = 1'b0;
                    end
                end
                n_fill = fill_mid;
                if (!i_item.pusi && fill_mid == '0) begin
                    status = STATUS_WAIT;
                end else begin
                    // A unit start closes the pending unit and restarts the fill,
                    // so the new unit always has room for this payload.
                    if (i_item.pusi) begin
                        deliver = (fill_mid != '0);
                        dlen    = fill_mid;
                        offset  = '0;
                        n_fill  = PAYLOAD_STEP;
                        status  = STATUS_APPEND;
                    end else if (fill_mid < FILL_LIMIT) begin
                        offset = fill_mid[OFFSET_W-1:0];
                        n_fill = fill_mid + PAYLOAD_STEP;
                        status = STATUS_APPEND;
                    end else begin
                        status = STATUS_OVERFLOW;
                    end
                end
            end
            default: status = STATUS_BAD_SYNC;
        endcase
    end

    // State advances only when a packet is taken from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_exp   <= '0;
            r_cc_known <= 1'b0;
            r_fill     <= '0;
            r_pcr_ms   <= '0;
        end else if (o_pop) begin
            r_cc_exp   <= n_cc_exp;
            r_cc_known <= n_cc_known;
            r_fill     <= n_fill;
            r_pcr_ms   <= n_pcr_ms;
        end
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_user <= status;
            r_out_data <= {2'd0, n_pcr_ms, offset, dlen, deliver, gap};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== rtl/tpfcc_checker.sv =====
`default_nettype none

module tpfcc_checker
    import tpfcc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_wr_en,
    input wire logic [PID_W-1:0]     i_cfg_wr_data,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic [S_TDATA_W-1:0] i_s_tdata,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic [M_TUSER_W-1:0] o_m_tuser
);

    // A delivered unit always starts a new fill, so the packet is appended.
    a_deliver_appends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> (o_m_tuser == STATUS_APPEND))
        else $error("delivery without append");

    // Without a delivery the reported length is zero.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[1]) |-> (o_m_tdata[14:2] == 13'd0))
        else $error("length reported without delivery");

    // A write offset appears only on appended packets.
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != STATUS_APPEND) |-> (o_m_tdata[26:15] == 12'd0))
        else $error("offset on a packet that was not appended");

    // A continuity gap is only reported for packets on the target PID.
    a_gap_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
        (o_m_tuser == STATUS_WAIT || o_m_tuser == STATUS_APPEND ||
         o_m_tuser == STATUS_OVERFLOW))
        else $error("gap on a packet outside the target PID");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind ts_pid_filter_continuity_check tpfcc_checker u_tpfcc_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Header beats are generated as mostly well-formed payload runs on the selected
// PID, mixed with rejected, null and foreign packets. Each beat's result is
// predicted when it is accepted and checked when its result beat comes out.
module tb_top;
    import tpfcc_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_HEAVY  = 53;
    localparam int IDLE_LIGHT  = 6;
    localparam int MAX_REPORTS = 10;

    // One header beat as it sits on i_s_tdata, header word in the low bits.
    typedef struct packed {
        logic [47:0] pcr;
        logic [7:0]  flags;
        logic [31:0] word;
    } t_hdr_beat;

    // One result beat, split into its fields.
    typedef struct {
        t_status              status;
        logic                 gap;
        logic                 deliver;
        logic [FILL_W-1:0]    dlen;
        logic [OFFSET_W-1:0]  offset;
        logic [PCR_MS_W-1:0]  pcr_ms;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [PID_W-1:0]     i_cfg_wr_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    ts_pid_filter_continuity_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Headers waiting to be sent and results waiting to be seen.
    t_hdr_beat pending_hdrs[$];
    t_result   expected_results[$];

    // Filter state as this bench predicts it.
    logic [PID_W-1:0]    sel_pid;
    logic [3:0]          cc_next;
    logic                cc_valid;
    logic [FILL_W-1:0]   fill_bytes;
    logic [PCR_MS_W-1:0] pcr_ms_latched;

    int       send_idle_pct = IDLE_NONE;
    int       recv_stall_pct = IDLE_NONE;
    logic [3:0] gen_cc = '0;
    int       mismatches = 0;
    int       cycles = 0;
    int       status_seen[0:6] = '{default: 0};
    int       gaps_seen = 0;
    int       deliveries_seen = 0;
    int       pid_settings = 0;

    // Work out the result of one header and advance the predicted state.
    function automatic t_result predict_packet(t_hdr_beat b);
        t_result     r;
        logic        pusi;
        logic        adapt;
        logic        disc;
        logic [12:0] pid;
        logic [3:0]  cc;
        logic [32:0] base;
        logic [8:0]  ext;
        pusi  = b.word[22];
        pid   = b.word[20:8];
        adapt = b.word[5];
        cc    = b.word[3:0];
        disc  = adapt & b.flags[7];
        r.status  = STATUS_BAD_SYNC;
        r.gap     = 1'b0;
        r.deliver = 1'b0;
        r.dlen    = '0;
        r.offset  = '0;
        if (b.word[31:24] != SYNC_BYTE) begin
            r.status = STATUS_BAD_SYNC;
        end else if (b.word[23]) begin
            r.status = STATUS_TERR;
        end else begin
            // The clock reference is latched only when a good packet's adaptation field holds one.
            if (adapt && b.flags[4]) begin
                base = b.pcr[47:15];
                ext  = b.pcr[8:0];
                pcr_ms_latched = PCR_MS_W'(base / 33'd90 + ext / 27000);
            end
            if (pid == NULL_PID) begin
                r.status = STATUS_NULL;
            end else if (pid != sel_pid) begin
                r.status = STATUS_OTHER;
            end else begin
                if (!cc_valid) begin
                    cc_next  = cc;
                    cc_valid = 1'b1;
                end else if (!disc) begin
                    cc_next = cc_next + 4'd1;
                    if (cc != cc_next) begin
                        r.gap      = 1'b1;
                        fill_bytes = '0;
                        cc_valid   = 1'b0;
                    end
                end
                if (!pusi && fill_bytes == 0) begin
                    r.status = STATUS_WAIT;
                end else begin
                    if (pusi && fill_bytes != 0) begin
                        r.deliver = 1'b1;
                        r.dlen    = fill_bytes;
                    end
                    if (pusi) fill_bytes = '0;
                    if (fill_bytes < BUFFER_BYTES - PAYLOAD_BYTES) begin
                        r.offset   = fill_bytes[OFFSET_W-1:0];
                        fill_bytes = fill_bytes + FILL_W'(PAYLOAD_BYTES);
                        r.status   = STATUS_APPEND;
                    end else begin
                        r.status = STATUS_OVERFLOW;
                    end
                end
            end
        end
        r.pcr_ms = pcr_ms_latched;
        return r;
    endfunction

    // Header word with the named fields set and the remaining bits random.
    function automatic logic [31:0] make_word(logic [7:0] sync, logic terr, logic pusi,
                                              logic [12:0] pid, logic adapt, logic [3:0] cc);
        logic [31:0] w;
        w        = $urandom;
        w[31:24] = sync;
        w[23]    = terr;
        w[22]    = pusi;
        w[20:8]  = pid;
        w[5]     = adapt;
        w[3:0]   = cc;
        return w;
    endfunction

    function automatic logic [47:0] rand_pcr();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return '1;
        if (pick == 1) return '0;
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic add_hdr(logic [31:0] word, logic [7:0] flags, logic [47:0] pcr);
        pending_hdrs.push_back(t_hdr_beat'({pcr, flags, word}));
    endtask

    // Short hand-picked sequence, run with PID 0 selected.
    task automatic add_directed();
        add_hdr(make_word(8'h00, 1'b1, 1'b1, NULL_PID, 1'b1, 4'hf), 8'hff, '1);
        add_hdr(make_word(8'hff, 1'b0, 1'b0, 13'h0, 1'b0, 4'h0), 8'h00, '0);
        // A transport error must not latch its clock reference.
        add_hdr(make_word(SYNC_BYTE, 1'b1, 1'b1, 13'h0, 1'b1, 4'h5), 8'h10, '1);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, NULL_PID, 1'b1, 4'h0), 8'h10, '1);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b1, 13'h1ffe, 1'b1, 4'h0), 8'h10, 48'h81ff);
        // First packet on the PID, then a unit with the counter wrapping.
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b0, 4'he), 8'h00, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b1, 13'h0, 1'b0, 4'hf), 8'h00, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b0, 4'h0), 8'h00, '0);
        // Counter gap flushes the fill; the next packet restarts the counter.
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b0, 4'h5), 8'h00, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b0, 4'h7), 8'h00, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b1, 13'h0, 1'b0, 4'h8), 8'h00, '0);
        // Discontinuity flag skips the counter check.
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b1, 4'h3), 8'h80, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b0, 4'h9), 8'h00, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b1, 13'h0, 1'b1, 4'ha), 8'h90,
                48'h1234_5678_9abc);
        // Without an adaptation field the discontinuity bit is ignored.
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b0, 13'h0, 1'b0, 4'h2), 8'h80, '0);
        add_hdr(make_word(SYNC_BYTE, 1'b0, 1'b1, 13'h0, 1'b0, 4'hc), 8'h00, '0);
    endtask

    // Random traffic: payload runs on the selected PID amid other packets.
    task automatic add_traffic(logic [12:0] pid_sel, int n);
        int          made;
        int          r;
        int          len;
        logic [31:0] w;
        logic [12:0] pid;
        logic [7:0]  flags;
        logic [3:0]  cc;
        logic        pusi;
        logic        adapt;
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 6) begin
                w = $urandom;
                if (w[31:24] == SYNC_BYTE) w[31:24] = ~w[31:24];
                add_hdr(w, 8'($urandom), rand_pcr());
                made++;
            end else if (r < 10) begin
                w = $urandom;
                w[31:24] = SYNC_BYTE;
                w[23] = 1'b1;
                add_hdr(w, 8'($urandom), rand_pcr());
                made++;
            end else if (r < 16) begin
                add_hdr(make_word(SYNC_BYTE, 1'b0, 1'($urandom), NULL_PID, 1'($urandom),
                                  4'($urandom)), 8'($urandom), rand_pcr());
                made++;
            end else if (r < 28) begin
                pid = ($urandom_range(3) == 0) ? 13'($urandom_range(1) * 13'h1ffe)
                                               : 13'($urandom_range(8190));
                if (pid == pid_sel) pid = pid ^ 13'h1;
                add_hdr(make_word(SYNC_BYTE, 1'b0, 1'($urandom), pid, 1'($urandom),
                                  4'($urandom)), 8'($urandom), rand_pcr());
                made++;
            end else if (r < 32) begin
                w = $urandom;
                if ($urandom_range(1) == 0) w[31:24] = SYNC_BYTE;
                add_hdr(w, 8'($urandom), rand_pcr());
                made++;
            end else begin
                // Mostly short units; now and then one long enough to overflow.
                len = ($urandom_range(14) == 0) ? $urandom_range(20, 26) : $urandom_range(0, 5);
                for (int k = 0; k <= len; k++) begin
                    gen_cc = gen_cc + 4'd1;
                    cc     = gen_cc;
                    pusi   = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
                    adapt  = 1'($urandom);
                    flags  = 8'($urandom);
                    flags[7] = ($urandom_range(24) == 0);
                    if ($urandom_range(99) < 6) cc = 4'($urandom);
                    if (adapt && flags[7]) begin
                        cc = 4'($urandom);
                        gen_cc = gen_cc - 4'd1;
                    end
                    add_hdr(make_word(SYNC_BYTE, 1'b0, pusi, pid_sel, adapt, cc), flags,
                            rand_pcr());
                    made++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_hdrs.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Select a PID while the block is idle, then queue the phase's traffic.
    task automatic run_phase(logic [12:0] pid_sel, int send_pct, int recv_pct, int n,
                             bit with_directed);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pid_sel;
        sel_pid = pid_sel;
        pid_settings++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (with_directed) add_directed();
        add_traffic(pid_sel, n);
    endtask

    // Header driver: predicts each accepted beat and presents the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_results.push_back(predict_packet(t_hdr_beat'(i_s_tdata)));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_hdrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tdata  <= pending_hdrs.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status  = t_status'(o_m_tuser);
                got.gap     = o_m_tdata[0];
                got.deliver = o_m_tdata[1];
                got.dlen    = o_m_tdata[14:2];
                got.offset  = o_m_tdata[26:15];
                got.pcr_ms  = o_m_tdata[53:27];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb_top: unexpected result beat, status %0d", got.status);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.gap !== want.gap
                        || got.deliver !== want.deliver || got.dlen !== want.dlen
                        || got.offset !== want.offset || got.pcr_ms !== want.pcr_ms) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"tb_top: mismatch status %0d/%0d gap %0d/%0d ",
                                      "deliver %0d/%0d len %0d/%0d offset %0d/%0d ",
                                      "pcr_ms %0d/%0d (expected/actual)"},
                                     want.status, got.status, want.gap, got.gap,
                                     want.deliver, got.deliver, want.dlen, got.dlen,
                                     want.offset, got.offset, want.pcr_ms, got.pcr_ms);
                    end
                end
                if (got.status <= STATUS_OVERFLOW) status_seen[got.status]++;
                if (got.gap) gaps_seen++;
                if (got.deliver) deliveries_seen++;
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("tb_top: run limit reached with %0d results outstanding",
                     expected_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Reset, then phases over several selected PIDs and idle patterns.
    initial begin
        sel_pid        = '0;
        cc_next        = '0;
        cc_valid       = 1'b0;
        fill_bytes     = '0;
        pcr_ms_latched = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(13'h0000, IDLE_NONE, IDLE_NONE, 200, 1'b1);
        run_phase(13'h1ffe, IDLE_HEAVY, IDLE_NONE, 220, 1'b0);
        run_phase(13'($urandom_range(8190)), IDLE_NONE, IDLE_HEAVY, 220, 1'b0);
        run_phase(13'h1fff, IDLE_LIGHT, IDLE_LIGHT, 100, 1'b0);
        run_phase(13'($urandom_range(8190)), IDLE_NONE, IDLE_NONE, 220, 1'b0);
        run_phase(13'h0001, IDLE_HEAVY, IDLE_NONE, 220, 1'b0);
        run_phase(13'($urandom_range(8190)), IDLE_NONE, IDLE_HEAVY, 220, 1'b0);
        run_phase(13'($urandom_range(8190)), IDLE_LIGHT, IDLE_LIGHT, 220, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) mismatches++;

        $display({"tb_top: %0d PID settings; results bad sync %0d, transport error %0d, ",
                  "null %0d, other %0d, waiting %0d, appended %0d, overflow %0d"},
                 pid_settings, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5], status_seen[6]);
        $display("tb_top: %0d continuity gaps, %0d unit deliveries, %0d mismatches",
                 gaps_seen, deliveries_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
